### design/aalr_pkg.sv
// ----------------------------------------------------------------------------
// aalr_pkg: shared types and constants
// Widths, operation codes and sequencer states of the line rasterizer.
// ----------------------------------------------------------------------------
package aalr_pkg;

    localparam int CoordW  = 28;
    localparam int SizeW   = 13;
    localparam int AccW    = 32;
    localparam int ChanW   = 8;
    localparam int PixW    = 12;
    localparam int QuotW   = 56;
    localparam int AddrW   = 3;
    localparam logic [31:0] OneFix   = 32'h0001_0000;
    localparam logic [31:0] FracMask = 32'h0000_FFFF;

    localparam logic OpLoad = 1'b0;
    localparam logic OpStep = 1'b1;

    localparam logic RegWidth  = 1'b0;
    localparam logic RegHeight = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_SLOPE,
        ST_DIV_PRE,
        ST_FINISH,
        ST_OUT
    } state_t;

    // request of a division to the shared divider
    typedef struct packed {
        logic              start;
        logic [QuotW-1:0]  num;    // magnitude
        logic [31:0]       den;    // magnitude, nonzero
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QuotW-1:0]  quot;   // rounded magnitude
    } div_rsp_t;

endpackage

### design/aalr_if.sv
// ----------------------------------------------------------------------------
// aalr_in_if / aalr_out_if: request and result channels
// Valid/ready channels carrying the line rasterizer payloads.
// ----------------------------------------------------------------------------
interface aalr_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic signed [27:0] start_x;
    logic signed [27:0] start_y;
    logic signed [27:0] end_x;
    logic signed [27:0] end_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    modport source (output valid, operation, start_x, start_y, end_x, end_y,
                    red, green, blue, input ready);
    modport sink (input valid, operation, start_x, start_y, end_x, end_y,
                  red, green, blue, output ready);
endinterface

interface aalr_out_if;
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        second_below;
    logic [7:0]  first_red;
    logic [7:0]  first_green;
    logic [7:0]  first_blue;
    logic [7:0]  second_red;
    logic [7:0]  second_green;
    logic [7:0]  second_blue;
    logic [12:0] steps_left;
    logic        last;
    modport source (output valid, write_valid, pixel_x, pixel_y, second_below,
                    first_red, first_green, first_blue, second_red,
                    second_green, second_blue, steps_left, last, input ready);
    modport sink (input valid, write_valid, pixel_x, pixel_y, second_below,
                  first_red, first_green, first_blue, second_red,
                  second_green, second_blue, steps_left, last, output ready);
endinterface

### design/aalr_divider.sv
// ----------------------------------------------------------------------------
// aalr_divider: shared restoring divider
// Unsigned magnitude division, one quotient bit per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module aalr_divider
    import aalr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CntW = $clog2(QuotW + 1);

    logic [QuotW-1:0] num_reg, num_next;
    logic [QuotW-1:0] quot_reg, quot_next;
    logic [33:0]      rem_reg, rem_next;
    logic [31:0]      den_reg, den_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [33:0]      trial;

    always_comb
    begin
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quot_next = '0;
            cnt_next  = CntW'(QuotW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial    = {rem_reg[32:0], num_reg[QuotW-1]};
            num_next = {num_reg[QuotW-2:0], 1'b0};
            if (trial >= {2'b00, den_reg})
            begin
                rem_next  = trial - {2'b00, den_reg};
                quot_next = {quot_reg[QuotW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[QuotW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    // round half up: remainder*2 >= den
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg + QuotW'({rem_reg[32:0], 1'b0} >= {2'b00, den_reg});

endmodule

### design/antialiased_line_rasterizer.sv
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer: anti-aliased DDA line rasterizer
// Loads a line, then emits one weighted pixel pair per step request.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries requests: operation 0 loads a line (endpoints, colour),
//          operation 1 asks for the next pixel pair.
//   out_ch carries one result per request, held in an output register until
//          taken; the block accepts nothing while a result waits.
//   APB    frame_width at 0x0, frame_height at 0x4, written while idle.
// Sequencing (request accepted to result valid):
//   step request: result valid in the cycle after it is accepted.
//   load request: setup, then two passes of the shared one-bit-per-cycle
//          divider (slope, then prestep offset), then finish. The next
//          request is taken once the result is taken and the block is idle.
//   A rejected line: result valid in the cycle after acceptance; a
//          single-point line skips the divider, from setup straight to finish.
// Reset clears the line state and restores frame 320 x 240. A stalled
// receiver holds the result; in_ch.ready stays low until it is taken.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer
    import aalr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    aalr_in_if.sink          in_ch,
    aalr_out_if.source       out_ch,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration
    logic [SizeW-1:0] width_reg, height_reg;
    logic [AddrW-3:0] reg_idx;
    assign reg_idx = paddr[AddrW-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd320;
            height_reg <= 13'd240;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                RegWidth:  width_reg  <= pwdata[SizeW-1:0];
                RegHeight: height_reg <= pwdata[SizeW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            RegWidth:  prdata = {19'd0, width_reg};
            RegHeight: prdata = {19'd0, height_reg};
            default:   prdata = '0;
        endcase
    end

    // line state
    state_t              state_reg, state_next;
    logic                active_reg, active_next;
    logic                ymaj_reg, ymaj_next;
    logic [AccW-1:0]     acc_reg, acc_next;
    logic [AccW-1:0]     inc_reg, inc_next;
    logic [SizeW-1:0]    pos_reg, pos_next;
    logic [SizeW-1:0]    rem_reg, rem_next;
    logic [23:0]         col_reg, col_next;
    // load scratch
    logic signed [29:0]  b1_reg, b1_next;      // minor start
    logic signed [29:0]  m_reg, m_next;        // minor extent
    logic [29:0]         d_reg, d_next;        // major extent
    logic [16:0]         pre_reg, pre_next;    // prestep, < 1.0 or up to -a1
    logic [28:0]         preb_reg, preb_next;  // full prestep magnitude
    logic [SizeW-1:0]    steps_reg, steps_next;
    logic                pend_reg, pend_next;  // prestep was stored in preb
    // result register
    logic                ovalid_reg, ovalid_next;
    logic                wv_reg, wv_next;
    logic [PixW-1:0]     px_reg, px_next, py_reg, py_next;
    logic                sb_reg, sb_next;
    logic [ChanW-1:0]    f_reg [3];
    logic [ChanW-1:0]    f_next [3];
    logic [ChanW-1:0]    s_reg [3];
    logic [ChanW-1:0]    s_next [3];
    logic [SizeW-1:0]    sl_reg, sl_next;
    logic                last_reg, last_next;

    div_req_t dreq;
    div_rsp_t drsp;

    aalr_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // load setup arithmetic
    logic signed [28:0] x1, y1, x2, y2, dx, dy, a1, a2, b1, b2, ta1, ta2, tb1, tb2;
    logic [28:0]        adx, ady;
    logic signed [29:0] wfix, hfix, sfix;
    logic               rej, ymaj;
    logic signed [14:0] lo, hi, ca2;
    logic signed [15:0] stp;
    logic [16:0]        pre_v;

    // step arithmetic
    logic signed [16:0] minor_px;
    logic [16:0]        frac, inv;
    logic signed [14:0] bound;
    logic [24:0]        prod_f [3];
    logic [24:0]        prod_s [3];
    logic [ChanW-1:0]   ch [3];

    // division operands
    logic [29:0]        m_mag;
    logic [28:0]        pre_mag;
    logic [QuotW-1:0]   pre_prod;

    // quotient magnitude to signed with wrap
    logic [QuotW-1:0]   q_signed;
    logic               neg_reg, neg_next;
    logic [AccW-1:0]    start_v;

    function automatic logic signed [14:0] ceil16(input logic signed [29:0] v);
        logic signed [29:0] t;
        logic [29:0] n;
        begin
            t = v + 30'sd65535;
            n = -v;
            if (v >= 0)
                ceil16 = 15'(t >>> 16);
            else
                ceil16 = -15'(n >> 16);
        end
    endfunction

    always_comb
    begin
        x1 = 29'(in_ch.start_x);
        y1 = 29'(in_ch.start_y);
        x2 = 29'(in_ch.end_x);
        y2 = 29'(in_ch.end_y);
        wfix = $signed({1'b0, width_reg, 16'd0});
        hfix = $signed({1'b0, height_reg, 16'd0});
        rej = (x1 < 0 && x2 < 0) || (y1 < 0 && y2 < 0)
            || (30'(x1) > wfix && 30'(x2) > wfix)
            || (30'(y1) > hfix && 30'(y2) > hfix);
        dx  = x2 - x1;
        dy  = y2 - y1;
        adx = dx[28] ? 29'(-dx) : 29'(dx);
        ady = dy[28] ? 29'(-dy) : 29'(dy);
        ymaj = ady > adx;
        ta1 = ymaj ? y1 : x1;
        ta2 = ymaj ? y2 : x2;
        tb1 = ymaj ? x1 : y1;
        tb2 = ymaj ? x2 : y2;
        sfix = ymaj ? hfix : wfix;
        if (ta1 > ta2)
        begin
            a1 = ta2; a2 = ta1; b1 = tb2; b2 = tb1;
        end
        else
        begin
            a1 = ta1; a2 = ta2; b1 = tb1; b2 = tb2;
        end
        lo    = (a1 >= 0) ? ceil16(30'(a1)) : 15'sd0;
        pre_v = 17'(({lo[12:0], 16'd0}) - 29'(a1));
        ca2   = ceil16(30'(a2));
        hi    = (30'(a2) >= sfix) ? $signed({2'b00, (ymaj ? height_reg : width_reg)}) : ca2;
        stp   = 16'(hi) - 16'(lo);
    end

    always_comb
    begin
        // ceiling of the 16.16 minor coordinate
        if (!acc_reg[31])
            minor_px = 17'($signed({1'b0, acc_reg[30:16]}) + 17'(acc_reg[15:0] != 16'd0));
        else
            minor_px = 17'($signed(acc_reg[31:16])) + 17'(acc_reg[15:0] != 16'd0);
        bound = $signed({2'b00, (ymaj_reg ? width_reg : height_reg)}) - 15'sd1;
        frac  = 17'(acc_reg & FracMask);
        inv   = 17'(OneFix) - frac;
        ch[0] = col_reg[23:16];
        ch[1] = col_reg[15:8];
        ch[2] = col_reg[7:0];
        for (int i = 0; i < 3; i++)
        begin
            prod_f[i] = frac * ch[i];
            prod_s[i] = inv * ch[i];
        end
        m_mag    = m_reg[29] ? 30'(-m_reg) : 30'(m_reg);
        pre_mag  = pend_reg ? preb_reg : 29'(pre_reg);
        // minor extent never exceeds the major extent, so this fits 56 bits
        pre_prod = QuotW'(pre_mag) * QuotW'(m_mag);
        q_signed = neg_reg ? QuotW'(-drsp.quot) : drsp.quot;
        start_v  = AccW'(32'(b1_reg) + q_signed[31:0]);
    end

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        ymaj_next   = ymaj_reg;
        acc_next    = acc_reg;
        inc_next    = inc_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        col_next    = col_reg;
        b1_next     = b1_reg;
        m_next      = m_reg;
        d_next      = d_reg;
        pre_next    = pre_reg;
        preb_next   = preb_reg;
        steps_next  = steps_reg;
        pend_next   = pend_reg;
        neg_next    = neg_reg;
        ovalid_next = ovalid_reg;
        wv_next     = wv_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        sb_next     = sb_reg;
        f_next      = f_reg;
        s_next      = s_reg;
        sl_next     = sl_reg;
        last_next   = last_reg;
        dreq        = '0;
        in_ch.ready = 1'b0;

        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = !ovalid_reg;
                if (in_ch.valid && !ovalid_reg)
                begin
                    wv_next = 1'b0; px_next = '0; py_next = '0; sb_next = 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        f_next[i] = '0;
                        s_next[i] = '0;
                    end
                    sl_next = '0;
                    last_next = 1'b1;
                    if (in_ch.operation == OpLoad)
                    begin
                        active_next = 1'b0;
                        rem_next    = '0;
                        if (rej)
                            ovalid_next = 1'b1;
                        else
                        begin
                            ymaj_next  = ymaj;
                            b1_next    = 30'(b1);
                            m_next     = 30'(b2) - 30'(b1);
                            d_next     = 30'(a2) - 30'(a1);
                            pre_next   = pre_v;
                            preb_next  = 29'(-a1);
                            pend_next  = (a1 < 0);
                            steps_next = stp[15] ? '0 : stp[SizeW-1:0];
                            pos_next   = lo[SizeW-1:0];
                            col_next   = {in_ch.red, in_ch.green, in_ch.blue};
                            state_next = ST_SETUP;
                        end
                    end
                    else if (active_reg)
                    begin
                        if (minor_px >= 0 && minor_px < 17'(bound))
                        begin
                            wv_next = 1'b1;
                            if (ymaj_reg)
                            begin
                                px_next = minor_px[PixW-1:0];
                                py_next = pos_reg[PixW-1:0];
                                sb_next = 1'b0;
                            end
                            else
                            begin
                                px_next = pos_reg[PixW-1:0];
                                py_next = minor_px[PixW-1:0];
                                sb_next = 1'b1;
                            end
                            for (int i = 0; i < 3; i++)
                            begin
                                f_next[i] = ch[i] - prod_f[i][23:16];
                                s_next[i] = ch[i] - prod_s[i][23:16];
                            end
                        end
                        acc_next  = acc_reg + inc_reg;
                        pos_next  = pos_reg + 1'b1;
                        rem_next  = rem_reg - 1'b1;
                        active_next = (rem_reg != 13'd1);
                        sl_next   = rem_reg - 1'b1;
                        last_next = (rem_reg == 13'd1);
                        ovalid_next = 1'b1;
                    end
                    else
                        ovalid_next = 1'b1;
                end
            end
            ST_SETUP:
            begin
                if (d_reg == '0)
                begin
                    inc_next = '0;
                    acc_next = AccW'(b1_reg);
                    state_next = ST_FINISH;
                end
                else
                begin
                    dreq.start = 1'b1;
                    dreq.num   = QuotW'({m_mag, 16'd0});
                    dreq.den   = {2'b00, d_reg};
                    neg_next   = m_reg[29];
                    state_next = ST_DIV_SLOPE;
                end
            end
            ST_DIV_SLOPE:
            begin
                if (drsp.done)
                begin
                    inc_next   = q_signed[31:0];
                    dreq.start = 1'b1;
                    dreq.num   = pre_prod;
                    dreq.den   = {2'b00, d_reg};
                    state_next = ST_DIV_PRE;
                end
            end
            ST_DIV_PRE:
            begin
                if (drsp.done)
                begin
                    acc_next   = start_v;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                rem_next    = steps_reg;
                active_next = (steps_reg != '0);
                sl_next     = steps_reg;
                last_next   = (steps_reg == '0);
                ovalid_next = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
            ymaj_reg   <= 1'b0;
            acc_reg    <= '0;
            inc_reg    <= '0;
            pos_reg    <= '0;
            rem_reg    <= '0;
            col_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            ymaj_reg   <= ymaj_next;
            acc_reg    <= acc_next;
            inc_reg    <= inc_next;
            pos_reg    <= pos_next;
            rem_reg    <= rem_next;
            col_reg    <= col_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg    <= b1_next;
        m_reg     <= m_next;
        d_reg     <= d_next;
        pre_reg   <= pre_next;
        preb_reg  <= preb_next;
        steps_reg <= steps_next;
        pend_reg  <= pend_next;
        neg_reg   <= neg_next;
        wv_reg    <= wv_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        sb_reg    <= sb_next;
        f_reg     <= f_next;
        s_reg     <= s_next;
        sl_reg    <= sl_next;
        last_reg  <= last_next;
    end

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.write_valid  = wv_reg;
    assign out_ch.pixel_x      = px_reg;
    assign out_ch.pixel_y      = py_reg;
    assign out_ch.second_below = sb_reg;
    assign out_ch.first_red    = f_reg[0];
    assign out_ch.first_green  = f_reg[1];
    assign out_ch.first_blue   = f_reg[2];
    assign out_ch.second_red   = s_reg[0];
    assign out_ch.second_green = s_reg[1];
    assign out_ch.second_blue  = s_reg[2];
    assign out_ch.steps_left   = sl_reg;
    assign out_ch.last         = last_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("request accepted while a load is in progress");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ch.ready) |=> ovalid_reg)
        else $error("result dropped while stalled");
    a_active_steps: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (rem_reg != '0))
        else $error("active line with no steps left");
    a_last_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && state_reg == ST_IDLE && last_reg) |-> !active_reg)
        else $error("last flagged while line still active");

endmodule
